/* hdl/ssrt_pkg.sv */
// Package for the sorted slot reservation table: field widths, status codes
// and the hour-span mask helper. No dependencies.
`default_nettype none
package ssrt_pkg;
    localparam int DefaultCapacity = 256;
    localparam int Days  = 7;
    localparam int Hours = 24;
    localparam int EntryW = 13;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_GUARDED = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_CONFLICT = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_READ     = 3'd4;

    // Hours covered by a reservation; caller guarantees hour + duration <= 24.
    function automatic logic [Hours-1:0] span_mask(input logic [4:0] hour,
                                                   input logic [4:0] duration);
        logic [47:0] ones;
        ones = (48'd1 << duration) - 48'd1;
        span_mask = ones[Hours-1:0] << hour;
    endfunction
endpackage
`default_nettype wire

/* hdl/sorted_slot_reservation_table_core.sv */
// Top level of the sorted slot reservation table.
// Depends on ssrt_pkg and ssrt_ram.
//
// One request enters on the s_ channel and one result leaves on the m_ channel.
// A request carries a kind: load insert, guarded insert (rejected if any hour
// it covers is already booked), or read of the entry at an index. Inserts keep
// the table sorted by day, then hour, with a new entry after equal keys.
// The table lives in one RAM with a registered read. An insert first scans
// from the top of the table downward: each cycle it reads one entry, and if
// that entry's key is after the new one it writes it one place up; the first
// entry that is not after the new key ends the scan and the new entry is
// written just above it. The 7 x 24 occupancy bitmap is kept in flip-flops
// and is checked in the request cycle.
// Reset clears the count and the bitmap; the table RAM needs no clearing since
// only positions below the count are read. The result sits in an output
// register; while the receiver stalls, the block holds the result and takes
// no new request until it is gone.
`default_nettype none
module sorted_slot_reservation_table_core
    import ssrt_pkg::*;
#(
    parameter int Capacity = DefaultCapacity
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // kind[1:0], day[4:2], hour[9:5], duration[14:10], read_index[22:15]
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], position[10:3], entry_total[19:11], out_day[22:20],
    // out_hour[27:23], out_duration[32:28]
    output logic [39:0]      m_tdata
);
    localparam int AW = $clog2(Capacity) > 0 ? $clog2(Capacity) : 1;
    localparam int CW = $clog2(Capacity + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_OUT} state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [Hours-1:0]   occ_reg [Days];
    logic [CW-1:0]      scan_reg;   // entry index being examined plus one
    logic [EntryW-1:0]  new_reg;
    logic [2:0]         status_reg;
    logic [7:0]         pos_reg;
    logic [2:0]         oday_reg;
    logic [4:0]         ohour_reg;
    logic [4:0]         odur_reg;
    logic               rdv_reg;    // read data of scan_reg-1 is valid

    logic [1:0] in_kind;
    logic [2:0] in_day;
    logic [4:0] in_hour, in_dur;
    logic [7:0] in_idx;
    assign in_kind = s_tdata[1:0];
    assign in_day  = s_tdata[4:2];
    assign in_hour = s_tdata[9:5];
    assign in_dur  = s_tdata[14:10];
    assign in_idx  = s_tdata[22:15];

    logic              wr_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [EntryW-1:0] wr_data, rd_data;

    ssrt_ram #(.Width(EntryW), .Depth(Capacity)) u_table (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    logic             range_err;
    logic [Hours-1:0] mask;
    logic [5:0]       hour_end;
    assign hour_end  = {1'b0, in_hour} + {1'b0, in_dur};
    assign range_err = (in_day >= 3'(Days)) || (in_hour >= 5'(Hours))
                       || (hour_end > 6'(Hours));
    assign mask      = span_mask(in_hour, in_dur);

    // Entry in RAM is {day, hour, duration}; compare keys day then hour.
    logic after_new;
    assign after_new = rd_data[12:5] > new_reg[12:5];

    logic in_fire;
    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = scan_reg[AW-1:0];
        wr_data = rd_data;
        rd_addr = AW'(in_idx);
        if (state_reg == S_SCAN) begin
            rd_addr = AW'(scan_reg - CW'(2));
            if (scan_reg == '0 || (rdv_reg && !after_new)) begin
                wr_en   = 1'b1;
                wr_data = new_reg;
            end else if (rdv_reg) begin
                wr_en = 1'b1;
            end
        end else if (state_reg == S_IDLE) begin
            rd_addr = AW'(count_reg - CW'(1));
        end
        if (in_fire && in_kind == KIND_READ) begin
            rd_addr = AW'(in_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            m_tvalid  <= 1'b0;
            rdv_reg   <= 1'b0;
            for (int d = 0; d < Days; d++) begin
                occ_reg[d] <= '0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        status_reg <= ST_READ;
                        pos_reg    <= '0;
                        oday_reg   <= '0;
                        ohour_reg  <= '0;
                        odur_reg   <= '0;
                        state_reg  <= S_OUT;
                        if (in_kind == KIND_LOAD || in_kind == KIND_GUARDED) begin
                            if (range_err) begin
                                status_reg <= ST_RANGE;
                            end else if (count_reg >= CW'(Capacity)) begin
                                status_reg <= ST_FULL;
                            end else if (in_kind == KIND_GUARDED &&
                                         (occ_reg[in_day] & mask) != '0) begin
                                status_reg <= ST_CONFLICT;
                            end else begin
                                occ_reg[in_day] <= occ_reg[in_day] | mask;
                                new_reg   <= {in_day, in_hour, in_dur};
                                scan_reg  <= count_reg;
                                rdv_reg   <= (count_reg != '0);
                                state_reg <= S_SCAN;
                            end
                        end else if (in_kind == KIND_READ) begin
                            pos_reg   <= in_idx;
                            state_reg <= (32'(in_idx) < 32'(count_reg)) ? S_READ : S_OUT;
                        end
                    end
                end
                S_SCAN: begin
                    if (wr_en && (scan_reg == '0 || !after_new)) begin
                        status_reg <= ST_INSERTED;
                        pos_reg    <= 8'(scan_reg);
                        count_reg  <= count_reg + CW'(1);
                        rdv_reg    <= 1'b0;
                        state_reg  <= S_OUT;
                    end else begin
                        scan_reg <= scan_reg - CW'(1);
                        rdv_reg  <= (scan_reg > CW'(1));
                    end
                end
                S_READ: begin
                    oday_reg  <= rd_data[12:10];
                    ohour_reg <= rd_data[9:5];
                    odur_reg  <= rd_data[4:0];
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_tvalid) begin
                        m_tvalid <= 1'b1;
                    end else if (m_tready) begin
                        m_tvalid  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic [8:0] total;
    assign total   = 9'(count_reg);
    assign m_tdata = {7'd0, odur_reg, ohour_reg, oday_reg, total, pos_reg, status_reg};

    // The table never holds more entries than it has room for.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(Capacity))
        else $error("entry count over capacity");
    // A request is taken only while no result is pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> !m_tvalid)
        else $error("request taken with result pending");
    // The count grows only by one, and only when an insert finishes.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + CW'(1))
        else $error("entry count moved by other than one");
endmodule
`default_nettype wire

/* hdl/ssrt_ram.sv */
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`default_nettype none
module ssrt_ram #(
    parameter int Width = 13,
    parameter int Depth = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire
